// ----- rtl/core/rbes_pkg.sv -----
// Shared types, constants and saturating helpers for the rigid body Euler step.
// Used by every module of the block; no dependencies of its own.
package rbes_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;

    // Register reset values in Q format
    localparam logic [63:0] MASS_RST64 = 64'd1 << FRAC_BITS;
    localparam logic [63:0] FC_RST64   = 64'd100 << FRAC_BITS;
    localparam logic [63:0] FG_RST64   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] LIM_RST64  = 64'd10000 << FRAC_BITS;
    localparam logic [31:0] MASS_RST = MASS_RST64[31:0];
    localparam logic [30:0] FC_RST   = (FC_RST64 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                  : FC_RST64[30:0];
    localparam logic [30:0] FG_RST   = FG_RST64[30:0];
    localparam logic [30:0] LIM_RST  = (LIM_RST64 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                   : LIM_RST64[30:0];

    // Configuration register indexes
    localparam logic [1:0] REG_MASS = 2'd0;
    localparam logic [1:0] REG_FC   = 2'd1;
    localparam logic [1:0] REG_FG   = 2'd2;
    localparam logic [1:0] REG_LIM  = 2'd3;

    typedef struct packed {
        logic [31:0] mass;
        logic [30:0] fc;
        logic [30:0] fg;
        logic [30:0] lim;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACC_DIV,
        OP_MUL_ADT,
        OP_ADD_V,
        OP_MUL_FCG,
        OP_FM_CLAMP,
        OP_MUL_FMM,
        OP_MUL_FMDT,
        OP_FM_SET,
        OP_MUL_FMSQ,
        OP_MUL_LIMSQ,
        OP_T_SAVE,
        OP_MUL_VSQ,
        OP_S2_SAVE,
        OP_S2_ADD,
        OP_ZERO_V,
        OP_SQRT,
        OP_MUL_VFM,
        OP_MUL_VLIM,
        OP_SC_DIV,
        OP_SUB_V,
        OP_SET_V,
        OP_MUL_VDT,
        OP_POS_ADD,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic axis;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic s2_lt;
        logic s2_gt;
        logic s2_zero;
        logic gnd;
        logic out_busy;
    } stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC_DIV,
        ST_ACC_WAIT,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_FM_MUL1,
        ST_FM_SAT1,
        ST_FM_MUL2,
        ST_FM_SAT2,
        ST_FM_MUL3,
        ST_FM_SET,
        ST_T_MUL,
        ST_LIM_MUL,
        ST_T_SAVE,
        ST_SQ_X_MUL,
        ST_SQ_X_SAVE,
        ST_SQ_Y_MUL,
        ST_SQ_Y_ADD,
        ST_DECIDE,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_SC_MUL,
        ST_SC_DIV,
        ST_SC_WAIT,
        ST_SC_APPLY,
        ST_POS_MUL,
        ST_POS_ADD,
        ST_FIN
    } state_t;

    // Magnitude of a signed word
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Apply a sign to a magnitude and saturate to signed 32 bits
    function automatic logic signed [31:0] sat_apply(input logic neg, input logic [63:0] m);
        logic signed [31:0] r;
        if (neg)
        begin
            r = (m >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-$signed(m[31:0]));
        end
        else
        begin
            r = (m >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
        end
        sat_apply = r;
    endfunction

    // Saturating signed add or subtract
    function automatic logic signed [31:0] sat_addsub(input logic signed [31:0] a,
                                                     input logic signed [31:0] b,
                                                     input logic sub);
        logic signed [33:0] s;
        s = sub ? (34'(a) - 34'(b)) : (34'(a) + 34'(b));
        if (s > 34'sh7FFF_FFFF)
        begin
            sat_addsub = 32'sh7FFF_FFFF;
        end
        else if (s < -34'sh8000_0000)
        begin
            sat_addsub = 32'sh8000_0000;
        end
        else
        begin
            sat_addsub = s[31:0];
        end
    endfunction

endpackage

// ----- rtl/core/rbes_div.sv -----
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor.
// Uses rbes_pkg only for house consistency; zero dividend yields zero quotient.
module rbes_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quot
);
    import rbes_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic        zero_reg, zero_next;
    logic [32:0] shifted;
    logic        ge;

    // One restoring step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[63]};
        ge        = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = 6'd63;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            zero_next = (dividend == 64'd0);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(shifted - {1'b0, den_reg}) : shifted[31:0];
            quo_next = {quo_reg[62:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign quot = zero_reg ? 64'd0 : quo_reg;

endmodule

// ----- rtl/core/rbes_sqrt.sv -----
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
// Uses rbes_pkg only for house consistency.
module rbes_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import rbes_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    // One root digit per step
    always_comb
    begin
        trial     = r_reg + bit_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = 5'd31;
            x_next    = radicand;
            r_next    = '0;
            bit_next  = 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

// ----- rtl/core/rbes_dpath.sv -----
// Datapath: shared 32x32 multiplier, divider and square root units, velocity state,
// work registers and the output word register. Depends on rbes_pkg, rbes_div, rbes_sqrt.
module rbes_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  rbes_pkg::cmd_t      cmd,
    output rbes_pkg::stat_t     stat,
    input  rbes_pkg::cfg_t      cfg,
    input  logic signed [31:0]  force_x,
    input  logic signed [31:0]  force_y,
    input  logic [15:0]         frame_time,
    input  logic                on_ground,
    input  logic signed [31:0]  pos_in_x,
    input  logic signed [31:0]  pos_in_y,
    input  logic                out_stall,
    output logic                out_valid,
    output logic signed [31:0]  pos_out_x,
    output logic signed [31:0]  pos_out_y,
    output logic signed [31:0]  vel_out_x,
    output logic signed [31:0]  vel_out_y
);
    import rbes_pkg::*;

    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [31:0] fx_reg, fy_reg, px_reg, px_next, py_reg, py_next;
    logic [15:0]        dt_reg;
    logic               gnd_reg;
    logic [31:0]        fm_reg, fm_next;
    logic [63:0]        prod_reg, t_reg, s2_reg, s2_next;
    logic               ov_reg, ov_next;
    logic signed [31:0] pox_reg, poy_reg, vox_reg, voy_reg;

    logic signed [31:0] v_sel, f_sel, p_sel, acc_val, sc_val, p_new, v_new;
    logic [31:0]        mul_a, mul_b;
    logic               mul_en;
    logic [63:0]        fm_sh;
    logic               div_start, div_done, sqrt_start, sqrt_done;
    logic [63:0]        div_dvd, quot;
    logic [31:0]        div_den, root;

    // Select the working axis
    always_comb
    begin
        v_sel = cmd.axis ? vy_reg : vx_reg;
        f_sel = cmd.axis ? fy_reg : fx_reg;
        p_sel = cmd.axis ? py_reg : px_reg;
    end

    // Shared units
    assign div_start  = (cmd.op == OP_ACC_DIV) || (cmd.op == OP_SC_DIV);
    assign div_dvd    = (cmd.op == OP_ACC_DIV) ? (64'(mag32(f_sel)) << FRAC_BITS) : prod_reg;
    assign div_den    = (cmd.op == OP_ACC_DIV) ? cfg.mass : root;
    assign sqrt_start = (cmd.op == OP_SQRT);

    rbes_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .done     (div_done),
        .quot     (quot)
    );

    rbes_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (s2_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    // Multiplier operand select
    always_comb
    begin
        acc_val = sat_apply(f_sel[31], quot);
        mul_en  = 1'b1;
        mul_a   = '0;
        mul_b   = '0;
        case (cmd.op)
            OP_MUL_ADT:
            begin
                mul_a = mag32(acc_val);
                mul_b = 32'(dt_reg);
            end
            OP_MUL_FCG:
            begin
                mul_a = {1'b0, cfg.fc};
                mul_b = {1'b0, cfg.fg};
            end
            OP_MUL_FMM:
            begin
                mul_a = fm_reg;
                mul_b = cfg.mass;
            end
            OP_MUL_FMDT:
            begin
                mul_a = fm_reg;
                mul_b = 32'(dt_reg);
            end
            OP_MUL_FMSQ:
            begin
                mul_a = fm_reg;
                mul_b = fm_reg;
            end
            OP_MUL_LIMSQ:
            begin
                mul_a = {1'b0, cfg.lim};
                mul_b = {1'b0, cfg.lim};
            end
            OP_MUL_VSQ:
            begin
                mul_a = mag32(v_sel);
                mul_b = mag32(v_sel);
            end
            OP_MUL_VFM:
            begin
                mul_a = mag32(v_sel);
                mul_b = fm_reg;
            end
            OP_MUL_VLIM:
            begin
                mul_a = mag32(v_sel);
                mul_b = {1'b0, cfg.lim};
            end
            OP_MUL_VDT:
            begin
                mul_a = mag32(v_sel);
                mul_b = 32'(dt_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Update velocity, position, friction and speed work registers
    always_comb
    begin
        fm_sh   = prod_reg >> FRAC_BITS;
        sc_val  = sat_apply(v_sel[31], quot);
        v_new   = v_sel;
        p_new   = sat_addsub(p_sel, sat_apply(v_sel[31], 64'(prod_reg[DT_BITS +: 32])), 1'b0);
        vx_next = vx_reg;
        vy_next = vy_reg;
        px_next = px_reg;
        py_next = py_reg;
        fm_next = fm_reg;
        s2_next = s2_reg;
        case (cmd.op)
            OP_ADD_V:
            begin
                v_new = sat_addsub(v_sel,
                                   sat_apply(f_sel[31], 64'(prod_reg[DT_BITS +: 32])), 1'b0);
            end
            OP_SUB_V:
            begin
                v_new = sat_addsub(v_sel, sc_val, 1'b1);
            end
            OP_SET_V:
            begin
                v_new = sc_val;
            end
            OP_FM_CLAMP:
            begin
                fm_next = (|fm_sh[63:32]) ? 32'hFFFF_FFFF : fm_sh[31:0];
            end
            OP_FM_SET:
            begin
                fm_next = prod_reg[DT_BITS +: 32];
            end
            OP_S2_SAVE:
            begin
                s2_next = prod_reg;
            end
            OP_S2_ADD:
            begin
                s2_next = s2_reg + prod_reg;
            end
            OP_POS_ADD:
            begin
                if (cmd.axis)
                begin
                    py_next = p_new;
                end
                else
                begin
                    px_next = p_new;
                end
            end
            default:
            begin
            end
        endcase
        if ((cmd.op == OP_ADD_V) || (cmd.op == OP_SUB_V) || (cmd.op == OP_SET_V))
        begin
            if (cmd.axis)
            begin
                vy_next = v_new;
            end
            else
            begin
                vx_next = v_new;
            end
        end
        if (cmd.op == OP_ZERO_V)
        begin
            vx_next = '0;
            vy_next = '0;
        end
        if (cmd.op == OP_LOAD)
        begin
            px_next = pos_in_x;
            py_next = pos_in_y;
        end
    end

    // Output word register: hold while stalled, drop once taken
    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.op == OP_OUT)
        begin
            ov_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg <= '0;
            vy_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        fm_reg <= fm_next;
        s2_reg <= s2_next;
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.op == OP_T_SAVE)
        begin
            t_reg <= prod_reg;
        end
        if (cmd.op == OP_LOAD)
        begin
            fx_reg  <= force_x;
            fy_reg  <= force_y;
            dt_reg  <= frame_time;
            gnd_reg <= on_ground;
        end
        if (cmd.op == OP_OUT)
        begin
            pox_reg <= px_reg;
            poy_reg <= py_reg;
            vox_reg <= vx_reg;
            voy_reg <= vy_reg;
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.div_done  = div_done;
        stat.sqrt_done = sqrt_done;
        stat.s2_lt     = s2_reg < t_reg;
        stat.s2_gt     = s2_reg > t_reg;
        stat.s2_zero   = (s2_reg == 64'd0);
        stat.gnd       = gnd_reg;
        stat.out_busy  = ov_reg & out_stall;
    end

    assign out_valid = ov_reg;
    assign pos_out_x = pox_reg;
    assign pos_out_y = poy_reg;
    assign vel_out_x = vox_reg;
    assign vel_out_y = voy_reg;

endmodule

// ----- rtl/core/rbes_ctrl.sv -----
// Sequencer for one frame step: issues datapath commands state by state.
// Depends on rbes_pkg for the state, command and status types.
module rbes_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rbes_pkg::stat_t  stat,
    output rbes_pkg::cmd_t   cmd
);
    import rbes_pkg::*;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   fric_reg, fric_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        fric_next  = fric_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACC_DIV;
                end
            end
            ST_ACC_DIV:   state_next = ST_ACC_WAIT;
            ST_ACC_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_ACC_MUL;
                end
            end
            ST_ACC_MUL:   state_next = ST_ACC_ADD;
            ST_ACC_ADD:
            begin
                axis_next = ~axis_reg;
                if (!axis_reg)
                begin
                    state_next = ST_ACC_DIV;
                end
                else if (stat.gnd)
                begin
                    state_next = ST_FM_MUL1;
                    fric_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_LIM_MUL;
                    fric_next  = 1'b0;
                end
            end
            ST_FM_MUL1:   state_next = ST_FM_SAT1;
            ST_FM_SAT1:   state_next = ST_FM_MUL2;
            ST_FM_MUL2:   state_next = ST_FM_SAT2;
            ST_FM_SAT2:   state_next = ST_FM_MUL3;
            ST_FM_MUL3:   state_next = ST_FM_SET;
            ST_FM_SET:    state_next = ST_T_MUL;
            ST_T_MUL:     state_next = ST_T_SAVE;
            ST_LIM_MUL:   state_next = ST_T_SAVE;
            ST_T_SAVE:    state_next = ST_SQ_X_MUL;
            ST_SQ_X_MUL:  state_next = ST_SQ_X_SAVE;
            ST_SQ_X_SAVE: state_next = ST_SQ_Y_MUL;
            ST_SQ_Y_MUL:  state_next = ST_SQ_Y_ADD;
            ST_SQ_Y_ADD:  state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (fric_reg)
                begin
                    if (stat.s2_lt || stat.s2_zero)
                    begin
                        state_next = ST_LIM_MUL;
                        fric_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_SQRT_GO;
                    end
                end
                else if (stat.s2_gt)
                begin
                    state_next = ST_SQRT_GO;
                end
                else
                begin
                    state_next = ST_POS_MUL;
                end
            end
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_SC_MUL;
                end
            end
            ST_SC_MUL:    state_next = ST_SC_DIV;
            ST_SC_DIV:    state_next = ST_SC_WAIT;
            ST_SC_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_SC_APPLY;
                end
            end
            ST_SC_APPLY:
            begin
                axis_next = ~axis_reg;
                if (!axis_reg)
                begin
                    state_next = ST_SC_MUL;
                end
                else if (fric_reg)
                begin
                    state_next = ST_LIM_MUL;
                    fric_next  = 1'b0;
                end
                else
                begin
                    state_next = ST_POS_MUL;
                end
            end
            ST_POS_MUL:   state_next = ST_POS_ADD;
            ST_POS_ADD:
            begin
                axis_next  = ~axis_reg;
                state_next = axis_reg ? ST_FIN : ST_POS_MUL;
            end
            ST_FIN:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd.axis = axis_reg;
        cmd.op   = OP_NONE;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_ACC_DIV:   cmd.op = OP_ACC_DIV;
            ST_ACC_MUL:   cmd.op = OP_MUL_ADT;
            ST_ACC_ADD:   cmd.op = OP_ADD_V;
            ST_FM_MUL1:   cmd.op = OP_MUL_FCG;
            ST_FM_SAT1:   cmd.op = OP_FM_CLAMP;
            ST_FM_MUL2:   cmd.op = OP_MUL_FMM;
            ST_FM_SAT2:   cmd.op = OP_FM_CLAMP;
            ST_FM_MUL3:   cmd.op = OP_MUL_FMDT;
            ST_FM_SET:    cmd.op = OP_FM_SET;
            ST_T_MUL:     cmd.op = OP_MUL_FMSQ;
            ST_LIM_MUL:   cmd.op = OP_MUL_LIMSQ;
            ST_T_SAVE:    cmd.op = OP_T_SAVE;
            ST_SQ_X_MUL:
            begin
                cmd.op   = OP_MUL_VSQ;
                cmd.axis = 1'b0;
            end
            ST_SQ_X_SAVE: cmd.op = OP_S2_SAVE;
            ST_SQ_Y_MUL:
            begin
                cmd.op   = OP_MUL_VSQ;
                cmd.axis = 1'b1;
            end
            ST_SQ_Y_ADD:  cmd.op = OP_S2_ADD;
            ST_DECIDE:
            begin
                if (fric_reg && stat.s2_lt)
                begin
                    cmd.op = OP_ZERO_V;
                end
            end
            ST_SQRT_GO:   cmd.op = OP_SQRT;
            ST_SC_MUL:    cmd.op = fric_reg ? OP_MUL_VFM : OP_MUL_VLIM;
            ST_SC_DIV:    cmd.op = OP_SC_DIV;
            ST_SC_APPLY:  cmd.op = fric_reg ? OP_SUB_V : OP_SET_V;
            ST_POS_MUL:   cmd.op = OP_MUL_VDT;
            ST_POS_ADD:   cmd.op = OP_POS_ADD;
            ST_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op = OP_OUT;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
            fric_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            fric_reg  <= fric_next;
        end
    end

endmodule

// ----- rtl/core/rigid_body_euler_step.sv -----
// Rigid body Euler step: one frame word in, one position and velocity word out.
// One item at a time: the divider is used up to six times per frame and the square root
// up to twice. A finished word waits in the output register while the next word is
// accepted. Reset clears velocity to zero and loads the default registers: mass 1.0,
// friction 100.0, gain 1.0, speed limit 10000.0.
module rigid_body_euler_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic [15:0]        frame_time,
    input  logic               on_ground,
    input  logic signed [31:0] pos_in_x,
    input  logic signed [31:0] pos_in_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_out_x,
    output logic signed [31:0] pos_out_y,
    output logic signed [31:0] vel_out_x,
    output logic signed [31:0] vel_out_y
);
    import rbes_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    cmd_t  cmd;
    stat_t stat;
    logic  wr_en;

    // Register writes on the access phase
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_MASS: cfg_next.mass = pwdata;
                REG_FC:   cfg_next.fc   = pwdata[30:0];
                REG_FG:   cfg_next.fg   = pwdata[30:0];
                REG_LIM:  cfg_next.lim  = pwdata[30:0];
                default:  cfg_next      = cfg_reg;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MASS: prdata = cfg_reg.mass;
            REG_FC:   prdata = {1'b0, cfg_reg.fc};
            REG_FG:   prdata = {1'b0, cfg_reg.fg};
            REG_LIM:  prdata = {1'b0, cfg_reg.lim};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mass <= MASS_RST;
            cfg_reg.fc   <= FC_RST;
            cfg_reg.fg   <= FG_RST;
            cfg_reg.lim  <= LIM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rbes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbes_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg        (cfg_reg),
        .force_x    (force_x),
        .force_y    (force_y),
        .frame_time (frame_time),
        .on_ground  (on_ground),
        .pos_in_x   (pos_in_x),
        .pos_in_y   (pos_in_y),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .pos_out_x  (pos_out_x),
        .pos_out_y  (pos_out_y),
        .vel_out_x  (vel_out_x),
        .vel_out_y  (vel_out_y)
    );

endmodule

// ----- sim/rbes_checker.sv -----
// Checker for the rigid body Euler step: watches the config port and both word channels,
// predicts each result word from its own copy of velocity and registers, and counts mismatches.
// Depends on rbes_pkg for register indexes and reset values.
module rbes_checker
    import rbes_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic [15:0]        frame_time,
    input  logic               on_ground,
    input  logic signed [31:0] pos_in_x,
    input  logic signed [31:0] pos_in_y,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] pos_out_x,
    input  logic signed [31:0] pos_out_y,
    input  logic signed [31:0] vel_out_x,
    input  logic signed [31:0] vel_out_y,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic [31:0] px, py, vx, vy;
    } step_t;

    step_t       step_q[$];
    logic [31:0] mass_r;
    logic [30:0] fc_r, fg_r, lim_r;
    longint      vel_x, vel_y;

    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;
    localparam longint M_CAP = 64'sd1 << 40;

    function automatic longint clip(input longint v);
        clip = v > S_MAX ? S_MAX : (v < S_MIN ? S_MIN : v);
    endfunction

    function automatic longint abs64(input longint v);
        abs64 = v < 0 ? -v : v;
    endfunction

    function automatic longint with_sign(input longint s, input logic [63:0] m);
        longint mm;
        mm = (m > 64'(M_CAP)) ? M_CAP : longint'(m);
        with_sign = clip(s < 0 ? -mm : mm);
    endfunction

    function automatic longint scale_dt(input longint v, input logic [63:0] t);
        logic [63:0] p;
        p = 64'(abs64(v)) * t;
        scale_dt = with_sign(v, p >> DT_BITS);
    endfunction

    function automatic longint scale_ratio(input longint v, input logic [63:0] m,
                                           input logic [63:0] d);
        logic [63:0] p;
        p = 64'(abs64(v)) * m;
        scale_ratio = with_sign(v, p / d);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        root64 = r;
    endfunction

    function automatic longint accel_of(input longint f);
        logic [63:0] m, q;
        m = 64'(abs64(f)) << FRAC_BITS;
        if (mass_r == 0) q = (m != 0) ? 64'(M_CAP) : 0;
        else q = m / 64'(mass_r);
        accel_of = with_sign(f, q);
    endfunction

    function automatic logic [63:0] cap32(input logic [63:0] v);
        cap32 = v > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic logic [63:0] speed_sq();
        logic [63:0] ax, ay;
        ax = 64'(abs64(vel_x));
        ay = 64'(abs64(vel_y));
        speed_sq = ax * ax + ay * ay;
    endfunction

    // Advance the body one frame and return the expected output word
    function automatic step_t euler_step(input longint fx, input longint fy,
                                         input logic [63:0] dt, input logic gnd,
                                         input longint px, input longint py);
        step_t       r;
        logic [63:0] fm, s2, sp, lim;
        vel_x = clip(vel_x + scale_dt(accel_of(fx), dt));
        vel_y = clip(vel_y + scale_dt(accel_of(fy), dt));
        if (gnd)
        begin
            fm = cap32((64'(fc_r) * 64'(fg_r)) >> FRAC_BITS);
            fm = cap32((fm * 64'(mass_r)) >> FRAC_BITS);
            fm = (fm * dt) >> DT_BITS;
            s2 = speed_sq();
            if (s2 < fm * fm)
            begin
                vel_x = 0;
                vel_y = 0;
            end
            else if (s2 != 0)
            begin
                sp = root64(s2);
                vel_x = clip(vel_x - scale_ratio(vel_x, fm, sp));
                vel_y = clip(vel_y - scale_ratio(vel_y, fm, sp));
            end
        end
        lim = 64'(lim_r);
        s2 = speed_sq();
        if (s2 > lim * lim)
        begin
            sp = root64(s2);
            vel_x = scale_ratio(vel_x, lim, sp);
            vel_y = scale_ratio(vel_y, lim, sp);
        end
        r.px = 32'(clip(px + scale_dt(vel_x, dt)));
        r.py = 32'(clip(py + scale_dt(vel_y, dt)));
        r.vx = 32'(vel_x);
        r.vy = 32'(vel_y);
        euler_step = r;
    endfunction

    assign pending = step_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        step_t e;
        if (!rst_n)
        begin
            mass_r = MASS_RST;
            fc_r = FC_RST;
            fg_r = FG_RST;
            lim_r = LIM_RST;
            vel_x = 0;
            vel_y = 0;
            fail_count = 0;
            step_q.delete();
        end
        else
        begin
            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_MASS: mass_r = pwdata;
                    REG_FC:   fc_r = pwdata[30:0];
                    REG_FG:   fg_r = pwdata[30:0];
                    REG_LIM:  lim_r = pwdata[30:0];
                    default: ;
                endcase
            end
            // Compare the result word with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (step_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word px=%h", pos_out_x);
                end
                else
                begin
                    e = step_q.pop_front();
                    if (e.px !== pos_out_x || e.py !== pos_out_y ||
                        e.vx !== vel_out_x || e.vy !== vel_out_y)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch exp %h %h %h %h got %h %h %h %h",
                                     e.px, e.py, e.vx, e.vy,
                                     pos_out_x, pos_out_y, vel_out_x, vel_out_y);
                    end
                end
            end
            // Predict each accepted input word
            if (in_valid && !in_stall)
                step_q.push_back(euler_step(force_x, force_y, frame_time, on_ground,
                                            pos_in_x, pos_in_y));
        end
    end

endmodule

// ----- sim/tb.sv -----
// Top of the rigid body Euler step testbench: clock, reset, config writes and stimulus.
// Depends on rbes_pkg, rigid_body_euler_step and rbes_checker.
module tb;
    import rbes_pkg::*;

    localparam int WATCHDOG = 200000;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0, in_stall;
    logic signed [31:0] force_x = 0, force_y = 0, pos_in_x = 0, pos_in_y = 0;
    logic [15:0] frame_time = 0;
    logic on_ground = 0;
    logic out_valid, out_stall = 0;
    logic signed [31:0] pos_out_x, pos_out_y, vel_out_x, vel_out_y;
    int fail_count, pending;
    int idle_cycles = 0;
    logic hold_off = 0;

    always #4 clk = ~clk;

    rigid_body_euler_step i_dut (.*);

    rbes_checker i_chk (.*);

    // Count cycles with no accepted word and end a hung run
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("rigid_body_euler_step verification failed");
            $finish;
        end
    end

    // Stall the result channel on its own pattern, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_off) out_stall <= 1;
        else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 2) != 0);
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    function automatic logic [31:0] rnd_word(input int kind);
        case (kind)
            0: rnd_word = 32'h7FFF_FFFF;
            1: rnd_word = 32'h8000_0000;
            2: rnd_word = 0;
            3: rnd_word = $urandom();
            default: rnd_word = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    task automatic send_frame(input logic [31:0] fx, input logic [31:0] fy,
                              input logic [15:0] dt, input logic g,
                              input logic [31:0] px, input logic [31:0] py);
        in_valid <= 1;
        force_x <= fx; force_y <= fy; frame_time <= dt; on_ground <= g;
        pos_in_x <= px; pos_in_y <= py;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_frames(input int n);
        int burst;
        int k;
        k = 0;
        while (k < n)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                send_frame(rnd_word($urandom_range(0, 6)), rnd_word($urandom_range(0, 6)),
                           ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom()),
                           1'($urandom()), rnd_word($urandom_range(0, 6)),
                           rnd_word($urandom_range(0, 6)));
                k++;
            end
            in_valid <= 0;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 300)) @(negedge clk);
        end
        in_valid <= 0;
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: field extremes, zero time, friction stop, clamp
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_frame(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_frame(0, 0, 16'hFFFF, 1, 0, 0);
        send_frame(0, 0, 16'h0000, 1, 32'h1234_5678, 32'hFEDC_BA98);
        send_frame(32'h0001_0000, 32'h0002_0000, 16'h0100, 1, 0, 0);
        send_frame(32'hFFFF_FFFF, 32'h0000_0001, 16'h8000, 0, 32'hFFFF_FFFF, 1);
        send_frame(0, 0, 16'h8000, 1, 0, 0);
        in_valid <= 0;
        drain();

        // Zero mass and huge friction
        reg_write(REG_MASS, 0);
        reg_write(REG_FC, 32'h7FFF_FFFF);
        reg_write(REG_FG, 32'h7FFF_FFFF);
        reg_write(REG_LIM, 32'h7FFF_FFFF);
        send_frame(32'h0001_0000, 32'hFFFF_0000, 16'hFFFF, 0, 0, 0);
        send_frame(0, 32'h8000_0000, 16'hFFFF, 0, 0, 0);
        send_frame(0, 0, 16'h0001, 1, 0, 0);
        send_frame(32'h7FFF_FFFF, 0, 16'hFFFF, 1, 0, 0);
        in_valid <= 0;
        drain();

        // Tight speed limit, no friction, max mass
        reg_write(REG_MASS, 32'hFFFF_FFFF);
        reg_write(REG_FC, 0);
        reg_write(REG_FG, 0);
        reg_write(REG_LIM, 0);
        send_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1, 5, 5);
        in_valid <= 0;
        drain();
        reg_write(REG_MASS, 1);
        reg_write(REG_LIM, 32'h0001_0000);
        send_frame(32'h0100_0000, 32'hFF00_0000, 16'hFFFF, 0, 0, 0);
        in_valid <= 0;
        drain();

        // Random phases under several settings
        for (int ph = 0; ph < 6; ph++)
        begin
            reg_write(REG_MASS, (ph == 0) ? 32'h0001_0000 : $urandom_range(1, 32'h0010_0000));
            reg_write(REG_FC, (ph == 1) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0100_0000));
            reg_write(REG_FG, (ph == 2) ? 0 : $urandom_range(0, 32'h0004_0000));
            reg_write(REG_LIM, (ph == 3) ? 0 : (ph == 4) ? 32'h7FFF_FFFF
                                             : $urandom_range(1, 32'h1000_0000));
            if (ph == 2)
            begin
                hold_off <= 1;
                fork
                    begin
                        repeat (3000) @(negedge clk);
                        hold_off <= 0;
                    end
                join_none
            end
            random_frames(315);
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("rigid_body_euler_step verification clean");
        else
            $display("rigid_body_euler_step verification failed");
        $finish;
    end

endmodule
